FILE: design/pressure_temperature_compensator_core_macros.svh
// Assertion macros shared by the compensator core.
`ifndef PRESSURE_TEMPERATURE_COMPENSATOR_CORE_MACROS_SVH
`define PRESSURE_TEMPERATURE_COMPENSATOR_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ptc_pkg.sv
// Types, constants and helpers shared by the compensator core.
package ptc_pkg;

    typedef struct packed {
        logic [7:0] press_msb;
        logic [7:0] press_lsb;
        logic [7:0] press_xlsb;
        logic [7:0] temp_msb;
        logic [7:0] temp_lsb;
        logic [7:0] temp_xlsb;
        logic       capture_baseline;
    } ptc_in_t;

    typedef struct packed {
        logic signed [15:0] temperature_centi;
        logic        [24:0] pressure_q8;
        logic signed [23:0] altitude_cm;
        logic               divisor_zero;
    } ptc_out_t;

    localparam logic [1:0] REG_TEMP_COEF  = 2'd0;
    localparam logic [1:0] REG_PRESS_LO   = 2'd1;
    localparam logic [1:0] REG_PRESS_HI   = 2'd2;
    localparam logic [1:0] REG_PRESS_LAST = 2'd3;

    localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = 64'sh8000_0000_0000_0001;
    localparam logic signed [64:0] SUM_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SUM_MIN = 65'sh1_8000_0000_0000_0001;

    // ceil(2^30 / 25): x / 25600 == ((x >> 10) * ALT_RECIP) >> 30 for x < 2^35.
    localparam logic signed [63:0] ALT_RECIP = 64'sd42949673;

    // Micro-op sequence, in execution order.
    typedef enum logic [5:0] {
        OP_TA_MUL, OP_TA_SET, OP_TD_MUL, OP_TD_SET, OP_TB_MUL, OP_FINE, OP_TEMP,
        OP_AA_MUL, OP_AA_SET, OP_P6_MUL, OP_P6_SET, OP_P5_MUL, OP_P5_SH, OP_P5_ADD,
        OP_P4_MUL, OP_P4_ADD, OP_P3_MUL, OP_P3_SET, OP_P2_MUL, OP_P2_SH, OP_P2_ADD,
        OP_P1_MUL, OP_P1_SET, OP_CHECK, OP_N_MUL, OP_N_SUB, OP_N3_MUL, OP_DIV,
        OP_Q_SET, OP_P9_MUL, OP_P9_SQ, OP_P9_SET, OP_P8_MUL, OP_P8_SET, OP_PRESS,
        OP_BASE, OP_DIFF_MUL, OP_ROUND, OP_ALT_DIV, OP_ALT
    } ptc_op_t;

    typedef struct packed {
        logic    load_in;
        logic    issue;
        ptc_op_t op;
        logic    load_out;
    } ptc_ctrl_t;

    typedef struct packed {
        logic unit_done;
        logic den_zero;
        logic out_free;
    } ptc_stat_t;

    function automatic logic op_is_mul(input ptc_op_t op);
        return op inside {OP_TA_MUL, OP_TD_MUL, OP_TB_MUL, OP_AA_MUL, OP_P6_MUL,
                          OP_P5_MUL, OP_P5_SH, OP_P4_MUL, OP_P3_MUL, OP_P2_MUL,
                          OP_P2_SH, OP_P1_MUL, OP_N_MUL, OP_N3_MUL, OP_P9_MUL,
                          OP_P9_SQ, OP_P8_MUL, OP_DIFF_MUL, OP_ALT_DIV};
    endfunction

    function automatic logic op_is_div(input ptc_op_t op);
        return op == OP_DIV;
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > SUM_MAX)
            return SAT_MAX;
        else if (s < SUM_MIN)
            return SAT_MIN;
        else
            return s[63:0];
    endfunction

endpackage

FILE: design/ptc_mul.sv
// Saturating 64-bit signed multiplier, four multiplier bits per cycle.
module ptc_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] x,
    input  logic signed [63:0] y,
    output logic               done,
    output logic signed [63:0] res
);

    localparam logic [63:0] SAT_MAX_U = 64'h7FFF_FFFF_FFFF_FFFF;

    logic               busy_reg, busy_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [63:0]        ua_reg, ua_next;
    logic [63:0]        ub_reg, ub_next;
    logic [62:0]        acc_reg, acc_next;
    logic               ovf_reg, ovf_next;
    logic               neg_reg, neg_next;
    logic               done_reg, done_next;
    logic signed [63:0] res_reg, res_next;

    logic [67:0]        prod;
    logic [68:0]        sum;
    logic               ovf_step;
    logic [62:0]        acc_step;
    logic signed [63:0] mag;

    always_comb
    begin
        prod     = ua_reg * ub_reg[63:60];
        sum      = 69'({acc_reg, 4'b0000}) + 69'(prod);
        ovf_step = ovf_reg | (sum > 69'(SAT_MAX_U));
        acc_step = ovf_step ? acc_reg : sum[62:0];
        mag      = ovf_step ? ptc_pkg::SAT_MAX : $signed({1'b0, acc_step});

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        ua_next   = ua_reg;
        ub_next   = ub_reg;
        acc_next  = acc_reg;
        ovf_next  = ovf_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            ua_next   = x[63] ? 64'(-x) : 64'(x);
            ub_next   = y[63] ? 64'(-y) : 64'(y);
            acc_next  = '0;
            ovf_next  = 1'b0;
            neg_next  = x[63] ^ y[63];
        end
        else if (busy_reg)
        begin
            ub_next  = {ub_reg[59:0], 4'b0000};
            acc_next = acc_step;
            ovf_next = ovf_step;
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = neg_reg ? -mag : mag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ua_reg  <= ua_next;
        ub_reg  <= ub_next;
        acc_reg <= acc_next;
        ovf_reg <= ovf_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

FILE: design/ptc_div.sv
// Signed 64-bit restoring divider, one quotient bit per cycle, truncating.
module ptc_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] n,
    input  logic signed [63:0] d,
    output logic               done,
    output logic signed [63:0] q
);

    logic               busy_reg, busy_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [63:0]        nq_reg, nq_next;
    logic [63:0]        dm_reg, dm_next;
    logic [63:0]        rem_reg, rem_next;
    logic               neg_reg, neg_next;
    logic               done_reg, done_next;
    logic signed [63:0] q_reg, q_next;

    logic [64:0] rs;
    logic [64:0] rdiff;
    logic        ge;
    logic [63:0] nq_step;

    always_comb
    begin
        rs      = {rem_reg, nq_reg[63]};
        rdiff   = rs - {1'b0, dm_reg};
        ge      = rs >= {1'b0, dm_reg};
        nq_step = {nq_reg[62:0], ge};

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        nq_next   = nq_reg;
        dm_next   = dm_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            nq_next   = n[63] ? 64'(-n) : 64'(n);
            dm_next   = d[63] ? 64'(-d) : 64'(d);
            rem_next  = '0;
            neg_next  = n[63] ^ d[63];
        end
        else if (busy_reg)
        begin
            nq_next  = nq_step;
            rem_next = ge ? rdiff[63:0] : rs[63:0];
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                q_next    = neg_reg ? -$signed(nq_step) : $signed(nq_step);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nq_reg  <= nq_next;
        dm_reg  <= dm_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

FILE: design/ptc_datapath.sv
// Datapath: coefficient registers, working registers, shared units, output register.
module ptc_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  ptc_pkg::ptc_ctrl_t  ctrl,
    output ptc_pkg::ptc_stat_t  stat,
    input  ptc_pkg::ptc_in_t    in_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                out_ready,
    output logic                out_valid,
    output ptc_pkg::ptc_out_t   out_data
);

    logic [47:0] tcoef_reg, tcoef_next;
    logic [63:0] plo_reg, plo_next;
    logic [63:0] phi_reg, phi_next;
    logic [15:0] p9_reg, p9_next;
    logic [24:0] base_reg, base_next;
    logic        out_valid_reg, out_valid_next;

    logic [19:0]        adc_p_reg, adc_p_next;
    logic [19:0]        adc_t_reg, adc_t_next;
    logic               cap_reg, cap_next;
    logic signed [63:0] ra_reg, ra_next;
    logic signed [63:0] rb_reg, rb_next;
    logic signed [63:0] rc_reg, rc_next;
    logic signed [63:0] rd_reg, rd_next;
    logic signed [15:0] temp_reg, temp_next;
    logic [24:0]        press_reg, press_next;
    logic signed [23:0] alt_reg, alt_next;
    logic               dz_reg, dz_next;
    logic               sgn_reg, sgn_next;
    ptc_pkg::ptc_out_t  out_reg, out_next;

    logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] adc_t64;
    logic signed [63:0] mul_x, mul_y, mres;
    logic signed [63:0] div_n, div_d, dres;
    logic               mul_done, div_done;
    logic               mul_start, div_start;
    logic signed [63:0] tmp, tmp2;

    function automatic logic signed [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    assign t1 = {48'd0, tcoef_reg[15:0]};
    assign t2 = sx16(tcoef_reg[31:16]);
    assign t3 = sx16(tcoef_reg[47:32]);
    assign p1 = {48'd0, plo_reg[15:0]};
    assign p2 = sx16(plo_reg[31:16]);
    assign p3 = sx16(plo_reg[47:32]);
    assign p4 = sx16(plo_reg[63:48]);
    assign p5 = sx16(phi_reg[15:0]);
    assign p6 = sx16(phi_reg[31:16]);
    assign p7 = sx16(phi_reg[47:32]);
    assign p8 = sx16(phi_reg[63:48]);
    assign p9 = sx16(p9_reg);
    assign adc_t64 = {44'd0, adc_t_reg};

    assign mul_start = ctrl.issue && ptc_pkg::op_is_mul(ctrl.op);
    assign div_start = ctrl.issue && ptc_pkg::op_is_div(ctrl.op);

    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        div_n = mres;
        div_d = ra_reg;
        case (ctrl.op)
            ptc_pkg::OP_TA_MUL:
            begin
                mul_x = (adc_t64 >>> 3) - (t1 <<< 1);
                mul_y = t2;
            end
            ptc_pkg::OP_TD_MUL:
            begin
                mul_x = (adc_t64 >>> 4) - t1;
                mul_y = (adc_t64 >>> 4) - t1;
            end
            ptc_pkg::OP_TB_MUL:   begin mul_x = rc_reg; mul_y = t3; end
            ptc_pkg::OP_AA_MUL:   begin mul_x = ra_reg; mul_y = ra_reg; end
            ptc_pkg::OP_P6_MUL:   begin mul_x = rc_reg; mul_y = p6; end
            ptc_pkg::OP_P5_MUL:   begin mul_x = ra_reg; mul_y = p5; end
            ptc_pkg::OP_P5_SH:    begin mul_x = mres; mul_y = 64'sd131072; end
            ptc_pkg::OP_P4_MUL:   begin mul_x = p4; mul_y = 64'sh8_0000_0000; end
            ptc_pkg::OP_P3_MUL:   begin mul_x = rc_reg; mul_y = p3; end
            ptc_pkg::OP_P2_MUL:   begin mul_x = ra_reg; mul_y = p2; end
            ptc_pkg::OP_P2_SH:    begin mul_x = mres; mul_y = 64'sd4096; end
            ptc_pkg::OP_P1_MUL:   begin mul_x = ra_reg; mul_y = p1; end
            ptc_pkg::OP_N_MUL:    begin mul_x = rc_reg; mul_y = 64'sh8000_0000; end
            ptc_pkg::OP_N3_MUL:   begin mul_x = rc_reg; mul_y = 64'sd3125; end
            ptc_pkg::OP_P9_MUL:   begin mul_x = p9; mul_y = rc_reg; end
            ptc_pkg::OP_P9_SQ:    begin mul_x = mres; mul_y = rc_reg; end
            ptc_pkg::OP_P8_MUL:   begin mul_x = p8; mul_y = rb_reg; end
            ptc_pkg::OP_DIFF_MUL:
            begin
                mul_x = $signed({39'd0, base_reg}) - $signed({39'd0, press_reg});
                mul_y = 64'sd843;
            end
            ptc_pkg::OP_ALT_DIV:
            begin
                mul_x = rd_reg >>> 10;
                mul_y = ptc_pkg::ALT_RECIP;
            end
            default:              begin mul_x = '0; mul_y = '0; end
        endcase
    end

    ptc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (mul_x),
        .y     (mul_y),
        .done  (mul_done),
        .res   (mres)
    );

    ptc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n     (div_n),
        .d     (div_d),
        .done  (div_done),
        .q     (dres)
    );

    always_comb
    begin
        tcoef_next     = tcoef_reg;
        plo_next       = plo_reg;
        phi_next       = phi_reg;
        p9_next        = p9_reg;
        base_next      = base_reg;
        out_valid_next = out_valid_reg;
        adc_p_next     = adc_p_reg;
        adc_t_next     = adc_t_reg;
        cap_next       = cap_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        rc_next        = rc_reg;
        rd_next        = rd_reg;
        temp_next      = temp_reg;
        press_next     = press_reg;
        alt_next       = alt_reg;
        dz_next        = dz_reg;
        sgn_next       = sgn_reg;
        out_next       = out_reg;
        tmp            = '0;
        tmp2           = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                ptc_pkg::REG_TEMP_COEF:  tcoef_next = cfg_data[47:0];
                ptc_pkg::REG_PRESS_LO:   plo_next   = cfg_data;
                ptc_pkg::REG_PRESS_HI:   phi_next   = cfg_data;
                ptc_pkg::REG_PRESS_LAST: p9_next    = cfg_data[15:0];
                default:                 p9_next    = p9_reg;
            endcase
        end

        if (ctrl.load_in)
        begin
            adc_p_next = {in_data.press_msb, in_data.press_lsb, in_data.press_xlsb[7:4]};
            adc_t_next = {in_data.temp_msb, in_data.temp_lsb, in_data.temp_xlsb[7:4]};
            cap_next   = in_data.capture_baseline;
        end

        if (ctrl.issue)
        begin
            case (ctrl.op)
                ptc_pkg::OP_TA_SET: ra_next = mres >>> 11;
                ptc_pkg::OP_TD_SET: rc_next = mres >>> 12;
                ptc_pkg::OP_FINE:   rd_next = ra_reg + (mres >>> 14);
                ptc_pkg::OP_TEMP:
                begin
                    tmp = ((rd_reg <<< 2) + rd_reg + 64'sd128) >>> 8;
                    if (tmp > 64'sd32767)
                        temp_next = 16'sh7FFF;
                    else if (tmp < -64'sd32768)
                        temp_next = 16'sh8000;
                    else
                        temp_next = tmp[15:0];
                    ra_next = rd_reg - 64'sd128000;
                end
                ptc_pkg::OP_AA_SET: rc_next = mres;
                ptc_pkg::OP_P6_SET: rb_next = mres;
                ptc_pkg::OP_P5_ADD: rb_next = ptc_pkg::sat_add(rb_reg, mres);
                ptc_pkg::OP_P4_ADD: rb_next = ptc_pkg::sat_add(rb_reg, mres);
                ptc_pkg::OP_P3_SET: rc_next = mres >>> 8;
                ptc_pkg::OP_P2_ADD:
                    ra_next = ptc_pkg::sat_add(64'sh8000_0000_0000,
                                               ptc_pkg::sat_add(rc_reg, mres));
                ptc_pkg::OP_P1_SET: ra_next = mres >>> 33;
                ptc_pkg::OP_CHECK:
                begin
                    dz_next    = (ra_reg == '0);
                    press_next = '0;
                    rc_next    = 64'sd1048576 - $signed({44'd0, adc_p_reg});
                end
                ptc_pkg::OP_N_SUB:  rc_next = ptc_pkg::sat_add(mres, -rb_reg);
                ptc_pkg::OP_Q_SET:
                begin
                    rb_next = dres;
                    rc_next = dres >>> 13;
                end
                ptc_pkg::OP_P9_SET: ra_next = mres >>> 25;
                ptc_pkg::OP_P8_SET:
                    rb_next = ptc_pkg::sat_add(ptc_pkg::sat_add(rb_reg, ra_reg), mres >>> 19);
                ptc_pkg::OP_PRESS:
                begin
                    tmp = ptc_pkg::sat_add(rb_reg >>> 8, p7 <<< 4);
                    if (tmp < 64'sd0)
                        press_next = '0;
                    else if (tmp > 64'sd33554431)
                        press_next = '1;
                    else
                        press_next = tmp[24:0];
                end
                ptc_pkg::OP_BASE:
                    if (cap_reg || base_reg == '0)
                        base_next = press_reg;
                ptc_pkg::OP_ROUND:
                begin
                    tmp      = mres[63] ? -mres : mres;
                    rd_next  = tmp + 64'sd12800;
                    sgn_next = mres[63];
                end
                ptc_pkg::OP_ALT:
                begin
                    tmp2 = sgn_reg ? -(mres >>> 30) : (mres >>> 30);
                    if (tmp2 > 64'sd8388607)
                        alt_next = 24'sh7FFFFF;
                    else if (tmp2 < -64'sd8388608)
                        alt_next = 24'sh800000;
                    else
                        alt_next = tmp2[23:0];
                end
                default: ;
            endcase
        end

        if (ctrl.load_out)
        begin
            out_next.temperature_centi = temp_reg;
            out_next.pressure_q8       = press_reg;
            out_next.altitude_cm       = alt_reg;
            out_next.divisor_zero      = dz_reg;
            out_valid_next             = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcoef_reg     <= '0;
            plo_reg       <= '0;
            phi_reg       <= '0;
            p9_reg        <= '0;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tcoef_reg     <= tcoef_next;
            plo_reg       <= plo_next;
            phi_reg       <= phi_next;
            p9_reg        <= p9_next;
            base_reg      <= base_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        adc_p_reg <= adc_p_next;
        adc_t_reg <= adc_t_next;
        cap_reg   <= cap_next;
        ra_reg    <= ra_next;
        rb_reg    <= rb_next;
        rc_reg    <= rc_next;
        rd_reg    <= rd_next;
        temp_reg  <= temp_next;
        press_reg <= press_next;
        alt_reg   <= alt_next;
        dz_reg    <= dz_next;
        sgn_reg   <= sgn_next;
        out_reg   <= out_next;
    end

    assign stat.unit_done = mul_done | div_done;
    assign stat.den_zero  = (ra_reg == '0);
    assign stat.out_free  = !out_valid_reg || out_ready;
    assign out_valid      = out_valid_reg;
    assign out_data       = out_reg;

endmodule

FILE: design/ptc_ctrl.sv
// Controller: steps the micro-op sequence and runs the item handshake.
module ptc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ptc_pkg::ptc_stat_t stat,
    output ptc_pkg::ptc_ctrl_t ctrl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_FINISH
    } state_t;

    state_t           state_reg, state_next;
    ptc_pkg::ptc_op_t pc_reg, pc_next;
    ptc_pkg::ptc_op_t pc_adv;

    always_comb
    begin
        if (pc_reg == ptc_pkg::OP_CHECK && stat.den_zero)
            pc_adv = ptc_pkg::OP_BASE;
        else
            pc_adv = ptc_pkg::ptc_op_t'(pc_reg + 6'd1);

        state_next = state_reg;
        pc_next    = pc_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    state_next = S_ISSUE;
                    pc_next    = ptc_pkg::OP_TA_MUL;
                end
            S_ISSUE:
                if (ptc_pkg::op_is_mul(pc_reg) || ptc_pkg::op_is_div(pc_reg))
                    state_next = S_WAIT;
                else if (pc_reg == ptc_pkg::OP_ALT)
                    state_next = S_FINISH;
                else
                    pc_next = pc_adv;
            S_WAIT:
                if (stat.unit_done)
                begin
                    state_next = S_ISSUE;
                    pc_next    = pc_adv;
                end
            S_FINISH:
                if (stat.out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= ptc_pkg::OP_TA_MUL;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign ctrl.load_in  = in_valid && (state_reg == S_IDLE);
    assign ctrl.issue    = (state_reg == S_ISSUE);
    assign ctrl.op       = pc_reg;
    assign ctrl.load_out = (state_reg == S_FINISH) && stat.out_free;

endmodule

FILE: design/pressure_temperature_compensator_core.sv
// Top level of the barometer pressure/temperature compensator.
//
//   port group   dir   handshake            payload
//   in_*         in    in_valid/in_ready    ptc_in_t  (six raw bytes, capture flag)
//   out_*        out   out_valid/out_ready  ptc_out_t (temp, pressure, altitude, flag)
//   cfg_*        in    cfg_we               cfg_index, 64-bit cfg_data
//
// An item runs from the accepting edge to the result as a sequence of micro-ops; when
// the pressure divisor is zero the pressure steps are skipped. Each of the 19 products
// goes through the shared multiplier (issue, 16 steps of 4 bits, handoff), the divide
// through the divider (issue, 64 bit steps, handoff); 20 ops need neither unit, plus accept and load.
// One item in flight; the next item is taken while a finished one waits at out.
// Reset clears coefficients, baseline and control; out_ready low holds the result.
`include "pressure_temperature_compensator_core_macros.svh"

module pressure_temperature_compensator_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ptc_pkg::ptc_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ptc_pkg::ptc_out_t out_data,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [63:0]       cfg_data
);

    ptc_pkg::ptc_ctrl_t ctrl;
    ptc_pkg::ptc_stat_t stat;

    ptc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    ptc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    `PTC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
    `PTC_ASSERT_NOW(a_issue_not_idle, ctrl.issue, !in_ready, "op issued while idle")
    `PTC_ASSERT_NOW(a_dz_zero_press, out_valid && out_data.divisor_zero, out_data.pressure_q8 == '0, "zero divisor with pressure")

endmodule

FILE: dv/pressure_temperature_compensator_core_tb.sv
// Self-checking testbench for the barometer pressure/temperature compensator core.
module pressure_temperature_compensator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint LIM = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 600;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    ptc_pkg::ptc_in_t  in_data;
    logic              out_valid;
    logic              out_ready;
    ptc_pkg::ptc_out_t out_data;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [63:0]       cfg_data;

    logic [47:0] coef_temp;
    logic [63:0] coef_press_lo;
    logic [63:0] coef_press_hi;
    logic [15:0] coef_p9;
    longint      baseline_q8;

    ptc_pkg::ptc_out_t expected_results[$];
    int          mismatches;
    int          idle_cycles;
    int          receiver_hold;
    bit          no_gaps;

    pressure_temperature_compensator_core u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    function automatic longint sat_product(input longint a, input longint b);
        logic signed [127:0] p;
        p = 128'(a) * 128'(b);
        if (p > LIM)
            return LIM;
        if (p < -LIM)
            return -LIM;
        return longint'(p);
    endfunction

    function automatic longint sat_sum(input longint a, input longint b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > LIM)
            return LIM;
        if (s < -LIM)
            return -LIM;
        return longint'(s);
    endfunction

    function automatic longint half_signed(input logic [15:0] h);
        logic signed [15:0] v;
        v = h;
        return longint'(v);
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Compensates one raw burst read and updates the altitude baseline when asked or while it is zero.
    function automatic ptc_pkg::ptc_out_t compensate(input ptc_pkg::ptc_in_t item);
        longint adc_p, adc_t, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        longint a, b, d, fine, temp, press, t, diff, num, alt;
        logic dz;
        ptc_pkg::ptc_out_t r;
        adc_p = {44'd0, item.press_msb, item.press_lsb, item.press_xlsb[7:4]};
        adc_t = {44'd0, item.temp_msb, item.temp_lsb, item.temp_xlsb[7:4]};
        t1 = {48'd0, coef_temp[15:0]};
        t2 = half_signed(coef_temp[31:16]);
        t3 = half_signed(coef_temp[47:32]);
        p1 = {48'd0, coef_press_lo[15:0]};
        p2 = half_signed(coef_press_lo[31:16]);
        p3 = half_signed(coef_press_lo[47:32]);
        p4 = half_signed(coef_press_lo[63:48]);
        p5 = half_signed(coef_press_hi[15:0]);
        p6 = half_signed(coef_press_hi[31:16]);
        p7 = half_signed(coef_press_hi[47:32]);
        p8 = half_signed(coef_press_hi[63:48]);
        p9 = half_signed(coef_p9);
        dz = 1'b0;

        a = (((adc_t >>> 3) - 2 * t1) * t2) >>> 11;
        d = (adc_t >>> 4) - t1;
        b = (((d * d) >>> 12) * t3) >>> 14;
        fine = a + b;
        temp = clamp((fine * 5 + 128) >>> 8, -32768, 32767);

        a = fine - 128000;
        b = sat_product(sat_product(a, a), p6);
        b = sat_sum(b, sat_product(sat_product(a, p5), longint'(1) << 17));
        b = sat_sum(b, sat_product(p4, longint'(1) << 35));
        a = sat_sum(sat_product(sat_product(a, a), p3) >>> 8,
                    sat_product(sat_product(a, p2), longint'(1) << 12));
        a = sat_product(sat_sum(longint'(1) << 47, a), p1) >>> 33;
        if (a == 0) begin
            dz = 1'b1;
            press = 0;
        end
        else begin
            press = 1048576 - adc_p;
            num = sat_product(sat_sum(sat_product(press, longint'(1) << 31), -b), 3125);
            press = num / a;
            t = press >>> 13;
            a = sat_product(sat_product(p9, t), t) >>> 25;
            b = sat_product(p8, press) >>> 19;
            press = sat_sum(sat_sum(sat_sum(press, a), b) >>> 8, p7 * 16);
            press = clamp(press, 0, 33554431);
        end

        if (item.capture_baseline || baseline_q8 == 0)
            baseline_q8 = press;
        diff = (baseline_q8 - press) * 843;
        if (diff >= 0)
            alt = (diff + 12800) / 25600;
        else
            alt = -((-diff + 12800) / 25600);
        alt = clamp(alt, -8388608, 8388607);

        r.temperature_centi = temp[15:0];
        r.pressure_q8 = press[24:0];
        r.altitude_cm = alt[23:0];
        r.divisor_zero = dz;
        return r;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    task automatic send_item(input ptc_pkg::ptc_in_t item);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge clk); while (!in_ready);
        expected_results.push_back(compensate(item));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
    endtask

    task automatic set_coefficients(input logic [47:0] tc, input logic [63:0] plo,
                                    input logic [63:0] phi, input logic [15:0] p9);
        cfg_we <= 1'b1;
        cfg_index <= ptc_pkg::REG_TEMP_COEF;
        cfg_data <= {16'd0, tc};
        @(posedge clk);
        cfg_index <= ptc_pkg::REG_PRESS_LO;
        cfg_data <= plo;
        @(posedge clk);
        cfg_index <= ptc_pkg::REG_PRESS_HI;
        cfg_data <= phi;
        @(posedge clk);
        cfg_index <= ptc_pkg::REG_PRESS_LAST;
        cfg_data <= {{48{p9[15]}}, p9};
        @(posedge clk);
        cfg_we <= 1'b0;
        coef_temp = tc;
        coef_press_lo = plo;
        coef_press_hi = phi;
        coef_p9 = p9;
    endtask

    task automatic set_typical();
        set_coefficients({16'hFC18, 16'd26435, 16'd27504},
                         {16'd2855, 16'd3024, 16'hD843, 16'd36477},
                         {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
    endtask

    function automatic ptc_pkg::ptc_in_t random_item(input int capture_odds);
        ptc_pkg::ptc_in_t item;
        item = ptc_pkg::ptc_in_t'(49'({$urandom, $urandom}));
        item.capture_baseline = ($urandom_range(0, capture_odds - 1) == 0);
        return item;
    endfunction

    // Plausible raw readings around normal conditions.
    function automatic ptc_pkg::ptc_in_t plausible_item();
        ptc_pkg::ptc_in_t item;
        logic [19:0] p, tr;
        item = random_item(8);
        p = 20'($urandom_range(300000, 700000));
        tr = 20'($urandom_range(400000, 600000));
        {item.press_msb, item.press_lsb, item.press_xlsb[7:4]} = p;
        {item.temp_msb, item.temp_lsb, item.temp_xlsb[7:4]} = tr;
        return item;
    endfunction

    task automatic test_reset_state();
        repeat (4) send_item(random_item(2));
        wait_drained();
    endtask

    task automatic test_directed();
        ptc_pkg::ptc_in_t item;
        set_typical();
        item = '0;
        send_item(item);
        item = '1;
        send_item(item);
        item = '0;
        item.press_msb = 8'hFF;
        item.press_lsb = 8'hFF;
        item.press_xlsb = 8'hF0;
        send_item(item);
        item = '0;
        item.temp_msb = 8'hFF;
        item.temp_lsb = 8'hFF;
        item.temp_xlsb = 8'hF0;
        item.capture_baseline = 1'b1;
        send_item(item);
        item = '0;
        item.press_xlsb = 8'h0F;
        item.temp_xlsb = 8'h0F;
        send_item(item);
        item = '0;
        item.press_xlsb = 8'hF0;
        item.temp_xlsb = 8'hF0;
        send_item(item);
        item = plausible_item();
        item.capture_baseline = 1'b1;
        send_item(item);
        repeat (3)
        begin
            item = plausible_item();
            item.capture_baseline = 1'b0;
            send_item(item);
        end
        item.capture_baseline = 1'b1;
        send_item(item);
        item.press_msb = 8'h20;
        item.capture_baseline = 1'b0;
        send_item(item);
        item.press_msb = 8'hF0;
        send_item(item);
        wait_drained();
    endtask

    task automatic test_coefficient_extremes();
        set_coefficients('1, '1, '1, '1);
        repeat (30) send_item(random_item(4));
        wait_drained();
        set_coefficients({3{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, 16'h8000);
        repeat (30) send_item(random_item(4));
        wait_drained();
        set_coefficients({3{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, 16'h7FFF);
        repeat (30) send_item(random_item(4));
        wait_drained();
        set_coefficients({32'd0, 16'hFFFF}, {48'd0, 16'hFFFF}, '0, '0);
        repeat (30) send_item(random_item(4));
        wait_drained();
    endtask

    task automatic test_random_coefficients();
        logic [15:0] h[12];
        repeat (4)
        begin
            h = '{16'd27504, 16'd26435, 16'hFC18, 16'd36477, 16'hD843, 16'd3024,
                  16'd2855, 16'd140, 16'hFFF9, 16'd15500, 16'hC6F8, 16'd6000};
            foreach (h[i])
                h[i] = h[i] + 16'($urandom_range(0, 2000)) - 16'd1000;
            set_coefficients({h[2], h[1], h[0]}, {h[6], h[5], h[4], h[3]},
                             {h[10], h[9], h[8], h[7]}, h[11]);
            repeat (100) send_item($urandom_range(0, 3) == 0 ? random_item(8)
                                                              : plausible_item());
            wait_drained();
        end
        repeat (3)
        begin
            set_coefficients(48'({$urandom, $urandom}), {$urandom, $urandom},
                             {$urandom, $urandom}, 16'($urandom));
            repeat (40) send_item(random_item(6));
            wait_drained();
        end
    endtask

    task automatic test_typical_random();
        set_typical();
        repeat (480) send_item($urandom_range(0, 2) == 0 ? random_item(8)
                                                          : plausible_item());
        wait_drained();
    endtask

    task automatic test_back_pressure();
        receiver_hold = 1200;
        repeat (6) send_item(plausible_item());
        wait_drained();
    endtask

    task automatic test_bursts();
        no_gaps = 1'b1;
        repeat (60) send_item(plausible_item());
        no_gaps = 1'b0;
        wait_drained();
    endtask

    task automatic test_sender_pause();
        repeat (5) send_item(plausible_item());
        wait_drained();
        repeat (5) send_item(random_item(3));
        wait_drained();
    endtask

    initial
    begin
        int gap;
        ptc_pkg::ptc_out_t want;
        @(posedge rst_n);
        forever
        begin
            if (receiver_hold > 0) begin
                out_ready <= 1'b0;
                repeat (receiver_hold) @(posedge clk);
                receiver_hold = 0;
            end
            gap = no_gaps ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (expected_results.size() == 0) begin
                report("unexpected result", 0, 0);
            end
            else begin
                want = expected_results.pop_front();
                if (out_data.temperature_centi !== want.temperature_centi)
                    report("temperature_centi", out_data.temperature_centi,
                           want.temperature_centi);
                if (out_data.pressure_q8 !== want.pressure_q8)
                    report("pressure_q8", out_data.pressure_q8, want.pressure_q8);
                if (out_data.altitude_cm !== want.altitude_cm)
                    report("altitude_cm", out_data.altitude_cm, want.altitude_cm);
                if (out_data.divisor_zero !== want.divisor_zero)
                    report("divisor_zero", out_data.divisor_zero, want.divisor_zero);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[pressure_temperature_compensator_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = ptc_pkg::REG_TEMP_COEF;
        cfg_data = '0;
        coef_temp = '0;
        coef_press_lo = '0;
        coef_press_hi = '0;
        coef_p9 = '0;
        baseline_q8 = 0;
        mismatches = 0;
        idle_cycles = 0;
        receiver_hold = 0;
        no_gaps = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed();
        test_coefficient_extremes();
        test_random_coefficients();
        test_typical_random();
        test_back_pressure();
        test_bursts();
        test_sender_pause();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("[pressure_temperature_compensator_core] OK");
        else
            $display("[pressure_temperature_compensator_core] ERROR");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+design
design/ptc_pkg.sv
design/ptc_mul.sv
design/ptc_div.sv
design/ptc_datapath.sv
design/ptc_ctrl.sv
design/pressure_temperature_compensator_core.sv
dv/pressure_temperature_compensator_core_tb.sv
